// File: design/mlsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsf_pkg
// Shared types, opcode table and float conversions for the misaligned
// load/store fixup block.
// ----------------------------------------------------------------------------
package mlsf_pkg;

    localparam int unsigned CfgW      = 9;
    localparam int unsigned InDataW   = 216;
    localparam int unsigned OutDataW  = 216;
    localparam logic [CfgW-1:0] LineBytesReset = 9'd128;

    localparam logic [6:0] OpcDcbz = 7'h5f;

    localparam logic [6:0] FlLd = 7'h01;
    localparam logic [6:0] FlSt = 7'h02;
    localparam logic [6:0] FlSe = 7'h04;
    localparam logic [6:0] FlF  = 7'h08;
    localparam logic [6:0] FlU  = 7'h10;
    localparam logic [6:0] FlM  = 7'h20;
    localparam logic [6:0] FlSw = 7'h40;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD_GPR  = 3'd1,
        OP_LOAD_FPR  = 3'd2,
        OP_STORE     = 3'd3,
        OP_ZERO_LINE = 3'd4
    } t_operation;

    typedef struct packed {
        logic [3:0] len;
        logic [6:0] flags;
    } t_op_entry;

    typedef struct packed {
        logic        status;
        t_operation  operation;
        logic [3:0]  access_length;
        logic [63:0] access_address;
        logic [4:0]  target_register;
        logic [63:0] register_write_value;
        logic [63:0] store_data;
        logic        base_update;
        logic [4:0]  base_register;
    } t_result;

    function automatic t_op_entry f_decode(input logic [6:0] opc);
        t_op_entry r;
        begin
            r = '{len: 4'd0, flags: 7'd0};
            unique case (opc)
                7'd0:   r = '{4'd4, FlLd};
                7'd2:   r = '{4'd4, FlSt};
                7'd4:   r = '{4'd2, FlLd};
                7'd5:   r = '{4'd2, FlLd | FlSe};
                7'd6:   r = '{4'd2, FlSt};
                7'd7:   r = '{4'd4, FlLd | FlM};
                7'd8:   r = '{4'd4, FlLd | FlF};
                7'd9:   r = '{4'd8, FlLd | FlF};
                7'd10:  r = '{4'd4, FlSt | FlF};
                7'd11:  r = '{4'd8, FlSt | FlF};
                7'd13:  r = '{4'd8, FlLd};
                7'd15:  r = '{4'd8, FlSt};
                7'd16:  r = '{4'd4, FlLd | FlU};
                7'd18:  r = '{4'd4, FlSt | FlU};
                7'd20:  r = '{4'd2, FlLd | FlU};
                7'd21:  r = '{4'd2, FlLd | FlSe | FlU};
                7'd22:  r = '{4'd2, FlSt | FlU};
                7'd23:  r = '{4'd4, FlSt | FlM};
                7'd24:  r = '{4'd4, FlLd | FlF | FlU};
                7'd25:  r = '{4'd8, FlLd | FlF | FlU};
                7'd26:  r = '{4'd4, FlSt | FlF | FlU};
                7'd27:  r = '{4'd8, FlSt | FlF | FlU};
                7'd32:  r = '{4'd8, FlLd};
                7'd34:  r = '{4'd8, FlSt};
                7'd37:  r = '{4'd4, FlLd | FlSe};
                7'd45:  r = '{4'd8, FlLd | FlU};
                7'd47:  r = '{4'd8, FlSt | FlU};
                7'd48:  r = '{4'd8, FlLd | FlU};
                7'd50:  r = '{4'd8, FlSt | FlU};
                7'd53:  r = '{4'd4, FlLd | FlSe | FlU};
                7'd72:  r = '{4'd4, FlLd | FlSw};
                7'd74:  r = '{4'd4, FlSt | FlSw};
                7'd76:  r = '{4'd2, FlLd | FlSw};
                7'd77:  r = '{4'd4, FlLd | FlSe};
                7'd78:  r = '{4'd2, FlSt | FlSw};
                7'd96:  r = '{4'd4, FlLd};
                7'd98:  r = '{4'd4, FlSt};
                7'd100: r = '{4'd2, FlLd};
                7'd101: r = '{4'd2, FlLd | FlSe};
                7'd102: r = '{4'd2, FlSt};
                7'd104: r = '{4'd4, FlLd | FlF};
                7'd105: r = '{4'd8, FlLd | FlF};
                7'd106: r = '{4'd4, FlSt | FlF};
                7'd107: r = '{4'd8, FlSt | FlF};
                7'd109: r = '{4'd8, FlLd | FlM};
                7'd111: r = '{4'd8, FlSt | FlM};
                7'd112: r = '{4'd4, FlLd | FlU};
                7'd114: r = '{4'd4, FlSt | FlU};
                7'd116: r = '{4'd2, FlLd | FlU};
                7'd117: r = '{4'd2, FlLd | FlSe | FlU};
                7'd118: r = '{4'd2, FlSt | FlU};
                7'd120: r = '{4'd4, FlLd | FlF | FlU};
                7'd121: r = '{4'd8, FlLd | FlF | FlU};
                7'd122: r = '{4'd4, FlSt | FlF | FlU};
                7'd123: r = '{4'd8, FlSt | FlF | FlU};
                default: r = '{4'd0, 7'd0};
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] f_len_mask(input logic [3:0] nb);
        logic [63:0] m;
        begin
            unique case (nb)
                4'd2:    m = 64'h0000_0000_0000_ffff;
                4'd4:    m = 64'h0000_0000_ffff_ffff;
                default: m = '1;
            endcase
            return m;
        end
    endfunction

    function automatic logic [63:0] f_sgl_to_dbl(input logic [31:0] s);
        logic        sg;
        logic [7:0]  e;
        logic [22:0] f;
        logic [4:0]  pos;
        logic [4:0]  lz;
        logic [22:0] nf;
        logic [10:0] ex;
        logic [63:0] r;
        begin
            sg  = s[31];
            e   = s[30:23];
            f   = s[22:0];
            pos = 5'd0;
            for (int i = 0; i < 23; i++) begin
                if (f[i]) pos = 5'(i);
            end
            lz = 5'd22 - pos;
            nf = f << (lz + 5'd1);
            ex = 11'd896 - {6'd0, lz};
            if (e == 8'hff) begin
                r = {sg, 11'h7ff, f, 29'd0};
            end else if (e == 8'd0) begin
                r = (f == 23'd0) ? {sg, 63'd0} : {sg, ex, nf, 29'd0};
            end else begin
                r = {sg, 11'({3'd0, e} + 11'd896), f, 29'd0};
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] f_dbl_to_sgl(input logic [63:0] d);
        logic               sg;
        logic [10:0]        e;
        logic [51:0]        f;
        logic [63:0]        mant;
        logic signed [12:0] se;
        logic signed [12:0] shs;
        logic [5:0]         sh;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic               inc;
        logic [32:0]        bits;
        logic [31:0]        r;
        begin
            sg   = d[63];
            e    = d[62:52];
            f    = d[51:0];
            mant = (e != 11'd0) ? {11'd0, 1'b1, f} : {12'd0, f};
            se   = $signed({2'b00, ((e != 11'd0) ? e : 11'd1)}) - 13'sd896;
            shs  = 13'sd30 - se;
            if (se >= 13'sd1) begin
                sh = 6'd29;
            end else if (se < -13'sd30) begin
                sh = 6'd60;
            end else begin
                sh = shs[5:0];
            end
            q    = mant >> sh;
            rem  = mant & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 6'd1);
            inc  = (rem > half) || ((rem == half) && q[0]);
            if (se >= 13'sd1) begin
                bits = ({20'd0, 13'(se - 13'sd1)} << 23) + 33'(q) + {32'd0, inc};
            end else begin
                bits = 33'(q) + {32'd0, inc};
            end
            if (bits >= 33'h0_7f80_0000) bits = 33'h0_7f80_0000;
            if (e == 11'h7ff) begin
                r = (f == 52'd0) ? {sg, 31'h7f80_0000}
                                 : ({sg, 31'h7fc0_0000} | {9'd0, f[51:29]});
            end else if (e == 11'd0 && f == 52'd0) begin
                r = {sg, 31'd0};
            end else if (se >= 13'sd255) begin
                r = {sg, 31'h7f80_0000};
            end else begin
                r = {sg, bits[30:0]};
            end
            return r;
        end
    endfunction

endpackage

// File: design/misaligned_load_store_fixup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// misaligned_load_store_fixup_top
// Decodes one alignment fault record into a refusal, a line zeroing, or a
// shaped load/store plan with single/double float conversion.
//
// Usage:
//   Slave stream carries one fault record per beat; tdata packs syndrome,
//   fault address, source value and memory bytes. Master stream returns one
//   plan per beat. The line size register is written through i_cfg_wr_en /
//   i_cfg_wr_data; write it only while no fault is in flight (the block
//   does not enforce this). Each plan passes the input register, then the
//   result register. Throughput: one beat per cycle while the receiver is
//   ready; the two register stages advance together with the downstream
//   ready, and an empty stage always takes a new beat.
//   Reset clears both valid flags and sets the line size to 128 bytes.
//   When the receiver stalls, the result holds and the input stage fills;
//   s_axis_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
module misaligned_load_store_fixup_top #(
    parameter logic [mlsf_pkg::CfgW-1:0] LINE_BYTES_RESET = mlsf_pkg::LineBytesReset
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // syndrome[19:0], fault_address[83:20], source_value[147:84],
    // memory_bytes[211:148], zero pad
    input  logic [mlsf_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[0], operation[3:1], access_length[7:4], access_address[71:8],
    // target_register[76:72], register_write_value[140:77],
    // store_data[204:141], base_update[205], base_register[210:206], zero pad
    output logic [mlsf_pkg::OutDataW-1:0]  m_axis_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [mlsf_pkg::CfgW-1:0]      i_cfg_wr_data
);
    import mlsf_pkg::*;

    logic                 r_in_valid;
    logic [InDataW-1:0]   r_in_data;
    logic                 r_out_valid;
    logic [OutDataW-1:0]  r_out_data;
    logic [CfgW-1:0]      r_line_bytes;

    logic                 adv_out;
    logic                 adv_in;
    logic [19:0]          syn;
    logic [63:0]          addr;
    logic [63:0]          src;
    logic [63:0]          mem;
    logic [6:0]           opc;
    t_op_entry            ent;
    logic [63:0]          msk;
    logic [63:0]          data;
    t_result              res;
    logic [OutDataW-1:0]  n_out_data;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv_in        = !r_in_valid || adv_out;
    assign s_axis_tready = adv_in;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign syn  = r_in_data[19:0];
    assign addr = r_in_data[83:20];
    assign src  = r_in_data[147:84];
    assign mem  = r_in_data[211:148];
    assign opc  = syn[16:10] | {syn[19:18], 5'd0};
    assign ent  = f_decode(opc);
    assign msk  = f_len_mask(ent.len);

    always_comb begin
        data = 64'd0;
        if ((ent.flags & FlLd) != 7'd0) data = mem & msk;
        if ((ent.flags & FlSt) != 7'd0) begin
            data = src;
            if ((ent.flags & FlF) != 7'd0 && ent.len == 4'd4) begin
                data = {src[63:32], f_dbl_to_sgl(src)};
            end
        end
        if ((ent.flags & FlSw) != 7'd0) begin
            if (ent.len == 4'd2) begin
                data = {data[63:16], data[7:0], data[15:8]};
            end else begin
                data = {data[63:32], data[7:0], data[15:8], data[23:16], data[31:24]};
            end
        end
        if ((ent.flags & FlSe) != 7'd0) begin
            if (ent.len == 4'd2) begin
                data = {{48{data[15]}}, data[15:0]};
            end else begin
                data = {{32{data[31]}}, data[31:0]};
            end
        end
        if ((ent.flags & FlLd) != 7'd0 && (ent.flags & FlF) != 7'd0 && ent.len == 4'd4) begin
            data = f_sgl_to_dbl(data[31:0]);
        end
    end

    always_comb begin
        res = '0;
        res.operation = OP_NONE;
        if (opc == OpcDcbz) begin
            res.operation      = OP_ZERO_LINE;
            res.access_address = addr & ~({55'd0, r_line_bytes} - 64'd1);
        end else if (ent.len == 4'd0 || (ent.flags & FlM) != 7'd0) begin
            res.status = 1'b1;
        end else begin
            res.access_length  = ent.len;
            res.access_address = addr;
            if ((ent.flags & FlLd) != 7'd0) begin
                res.operation            = ((ent.flags & FlF) != 7'd0) ? OP_LOAD_FPR
                                                                       : OP_LOAD_GPR;
                res.target_register      = syn[9:5];
                res.register_write_value = data;
            end else begin
                res.operation  = OP_STORE;
                res.store_data = data & msk;
            end
            if ((ent.flags & FlU) != 7'd0) begin
                res.base_update   = 1'b1;
                res.base_register = syn[4:0];
            end
        end
        n_out_data = {5'd0, res.base_register, res.base_update, res.store_data,
                      res.register_write_value, res.target_register, res.access_address,
                      res.access_length, res.operation, res.status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_bytes <= LINE_BYTES_RESET;
        end else begin
            if (i_cfg_wr_en) r_line_bytes <= i_cfg_wr_data;
            if (adv_in) r_in_valid <= s_axis_tvalid;
            if (adv_out) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && s_axis_tvalid) r_in_data <= s_axis_tdata;
        if (adv_out && r_in_valid) r_out_data <= n_out_data;
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("input stage did not advance into empty result stage");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[OutDataW-1:1] == '0)
        else $error("refused plan carries nonzero fields");

    a_zero_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:1] == OP_ZERO_LINE
        |-> m_axis_tdata[7:4] == 4'd0 && !m_axis_tdata[205])
        else $error("line zeroing with length or base update");

endmodule
